FILE: sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int OP_W  = 63;  // widest streamed operand (base value)
  localparam int MOD_W = 31;  // modulus and residue width
  localparam int CNT_W = 6;   // holds OP_W

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
  localparam logic [CNT_W-1:0] REDUCE_BITS   = 6'd63;
  localparam logic [CNT_W-1:0] MUL_BITS      = 6'd31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  // Request to the shared modular multiply unit
  typedef struct packed {
    logic             start;
    logic [OP_W-1:0]  operand;  // streamed MSB first from bit OP_W-1
    logic [MOD_W-1:0] addend;
    logic [CNT_W-1:0] nbits;
  } mm_req_t;

endpackage

FILE: sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: residue = base_value^exponent mod modulus.
// ----------------------------------------------------------------------------
// One item at a time, all arithmetic on one bit-serial modular multiplier.
// The base is first reduced mod the modulus; then for every exponent bit up
// to the highest set one the result is multiplied by the square when the bit
// is set, and the square is squared (the final square is skipped); exponent
// 0 finishes after the reduction with a residue of 1. A modulus below 2 gives
// 0 without starting the multiplier. The multiplier retires one operand bit
// per cycle, and each modular product ends with its done pulse. in_ready is
// high only while idle; a finished residue waits in the output register
// while the next beat is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int EXPONENT_BITS = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mexp_pkg::OP_W-1:0]  in_base_value,
  input  logic [mexp_pkg::OP_W-1:0]  in_exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mexp_pkg::MOD_W-1:0] out_residue
);
  import mexp_pkg::*;

  state_t                   state_r, state_nxt;
  logic [MOD_W-1:0]         modulus_r;
  logic [EXPONENT_BITS-1:0] exp_r, exp_nxt;
  logic [MOD_W-1:0]         acc_r, acc_nxt;
  logic [MOD_W-1:0]         sq_r, sq_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0]         out_residue_r, out_residue_nxt;

  mm_req_t          mm_req;
  logic             mm_done;
  logic [MOD_W-1:0] mm_result;

  logic in_fire;
  logic mod_small;
  logic exp_rest_zero;  // nothing left above the current bit
  logic out_load;

  assign in_fire       = in_valid && in_ready;
  assign mod_small     = (modulus_r < 2);
  assign exp_rest_zero = ((exp_r >> 1) == '0);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .modulus (modulus_r),
    .done    (mm_done),
    .result  (mm_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = mod_small ? S_DONE : S_REDUCE;
      end
      S_REDUCE: begin
        if (mm_done) state_nxt = S_STEP;
      end
      S_STEP: begin
        if (exp_r == '0)   state_nxt = S_DONE;
        else if (exp_r[0]) state_nxt = S_MUL;
        else               state_nxt = S_SQR;
      end
      S_MUL: begin
        if (mm_done) state_nxt = exp_rest_zero ? S_DONE : S_SQR;
      end
      S_SQR: begin
        if (mm_done) state_nxt = S_STEP;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier requests
  always_comb begin
    in_ready       = 1'b0;
    mm_req.start   = 1'b0;
    mm_req.operand = {sq_r, {(OP_W-MOD_W){1'b0}}};
    mm_req.addend  = sq_r;
    mm_req.nbits   = MUL_BITS;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // reduce the base: stream its bits against addend 1
        mm_req.start   = in_fire && !mod_small;
        mm_req.operand = in_base_value;
        mm_req.addend  = {{(MOD_W-1){1'b0}}, 1'b1};
        mm_req.nbits   = REDUCE_BITS;
      end
      S_STEP: begin
        mm_req.start = (exp_r != '0);
        if (exp_r[0]) mm_req.operand = {acc_r, {(OP_W-MOD_W){1'b0}}};
      end
      S_MUL: begin
        mm_req.start = mm_done && !exp_rest_zero;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    exp_nxt         = exp_r;
    acc_nxt         = acc_r;
    sq_nxt          = sq_r;
    out_valid_nxt   = out_valid_r;
    out_residue_nxt = out_residue_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          exp_nxt = in_exponent[EXPONENT_BITS-1:0];
          acc_nxt = mod_small ? '0 : {{(MOD_W-1){1'b0}}, 1'b1};
        end
      end
      S_REDUCE: begin
        if (mm_done) sq_nxt = mm_result;
      end
      S_MUL: begin
        if (mm_done) acc_nxt = mm_result;
      end
      S_SQR: begin
        if (mm_done) begin
          sq_nxt  = mm_result;
          exp_nxt = exp_r >> 1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_residue_nxt = acc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) modulus_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    exp_r         <= exp_nxt;
    acc_r         <= acc_nxt;
    sq_r          <= sq_nxt;
    out_residue_r <= out_residue_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

endmodule

FILE: sv/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiply: r = (operand * addend) mod modulus,
// one operand bit per cycle, MSB first. With addend 1 it reduces the operand.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mexp_pkg::mm_req_t       req,
  input  logic [mexp_pkg::MOD_W-1:0] modulus,
  output logic                    done,
  output logic [mexp_pkg::MOD_W-1:0] result
);
  import mexp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic [OP_W-1:0]  opnd_r, opnd_nxt;
  logic [MOD_W-1:0] add_r, add_nxt;

  logic [MOD_W+1:0] sum;    // 2r + addend < 3m
  logic [MOD_W+2:0] diff1;  // sum - m
  logic [MOD_W+2:0] diff2;  // sum - 2m
  logic [MOD_W-1:0] acc_step;

  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + {2'b00, (opnd_r[OP_W-1] ? add_r : {MOD_W{1'b0}})};
    diff1 = {1'b0, sum} - {3'b000, modulus};
    diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
    if (!diff2[MOD_W+2]) begin
      acc_step = diff2[MOD_W-1:0];
    end else if (!diff1[MOD_W+2]) begin
      acc_step = diff1[MOD_W-1:0];
    end else begin
      acc_step = sum[MOD_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    opnd_nxt = opnd_r;
    add_nxt  = add_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      acc_nxt  = '0;
      opnd_nxt = req.operand;
      add_nxt  = req.addend;
    end else if (busy_r) begin
      acc_nxt  = acc_step;
      opnd_nxt = {opnd_r[OP_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opnd_r <= opnd_nxt;
    add_r  <= add_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
